// ----- src/sdtq_pkg.sv -----
// Shared types and constants for the sorted deadline timer queue.
// Used by sdtq_cell and sorted_deadline_timer_queue_unit; depends on nothing.
`default_nettype none

package sdtq_pkg;

    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 8;

    // Opcodes of an input item.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_EXPIRE = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_ADDED    = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED  = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    typedef struct packed {
        logic                 opcode;
        logic [TIME_BITS-1:0] time_us;
        logic [ID_BITS-1:0]   timer_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ID_BITS-1:0]   expired_id;
        logic [TIME_BITS-1:0] expired_deadline;
        logic                 rearm;
        logic [TIME_BITS-1:0] next_deadline;
        logic                 queue_empty;
        logic                 last;
    } t_out_item;

    // One queued timer.
    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [ID_BITS-1:0]   id;
    } t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE,
        S_EXPIRE
    } t_state;

endpackage

`default_nettype wire

// ----- src/sdtq_cell.sv -----
// One slot of the sorted timer chain: holds a deadline and id and trades
// them with its neighbors on insert and pop. Depends on sdtq_pkg.
`default_nettype none

module sdtq_cell (
    input  wire logic               i_clk,
    input  wire sdtq_pkg::t_cell_ctrl i_ctrl,
    input  wire sdtq_pkg::t_entry   i_new,
    input  wire logic               i_occupied,
    input  wire sdtq_pkg::t_entry   i_prev,
    input  wire logic               i_prev_after,
    input  wire sdtq_pkg::t_entry   i_next,
    output sdtq_pkg::t_entry        o_entry,
    output logic                    o_after
);

    sdtq_pkg::t_entry r_entry;
    sdtq_pkg::t_entry n_entry;

    // An empty slot counts as sorting after any new timer; equal deadlines
    // keep the older entry first when ids are equal too.
    assign o_after = !i_occupied
                     || (r_entry.deadline > i_new.deadline)
                     || ((r_entry.deadline == i_new.deadline) && (r_entry.id > i_new.id));

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_entry = i_next;
        end else if (i_ctrl.insert && o_after) begin
            n_entry = i_prev_after ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ----- src/sorted_deadline_timer_queue_unit.sv -----
// Top level of the sorted deadline timer queue: a chain of sdtq_cell slots,
// the sequencer and the result register. Depends on sdtq_pkg and sdtq_cell.
//
// Usage: input items arrive on the in channel (i_in_valid / o_in_ready,
// payload i_in_data) and results leave on the out channel (o_out_valid /
// i_out_ready, payload o_out_data). Each channel moves one item per transfer.
// An add inserts a timer in its sorted place: every slot of the
// chain compares its own entry against the new one, and the slots behind the
// insertion point shift one place toward the tail. Adds are taken one per
// cycle while the receiver keeps up, and the result is shown the cycle after
// the transfer. An expire item first captures the time, then emits one
// expired timer per cycle while the receiver keeps up, by popping the head
// slot and shifting the whole chain one place toward the head; when nothing
// expired, the single "nothing expired" result goes out. The head slot and
// its successor decide whether the current result is the last one.
// Results sit in an output register; the next add may be taken while the
// previous result is being transferred. When the receiver stalls, the result
// register holds and the block stops accepting items or popping timers.
// Reset clears the entry count, the sequencer and the result valid flag; slot
// contents are left as they are and are only read below the count.
`default_nettype none

module sorted_deadline_timer_queue_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sdtq_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sdtq_pkg::t_out_item      o_out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sdtq_pkg::t_state     r_state;
    sdtq_pkg::t_state     n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [sdtq_pkg::TIME_BITS-1:0] r_now;
    logic                 r_out_valid;
    sdtq_pkg::t_out_item  r_out;
    sdtq_pkg::t_out_item  n_out;
    logic                 load_out;
    logic                 can_load;
    logic                 in_xfer;
    sdtq_pkg::t_cell_ctrl cell_ctrl;
    sdtq_pkg::t_entry     new_entry;

    sdtq_pkg::t_entry     c_entry [QUEUE_DEPTH];
    logic                 c_after [QUEUE_DEPTH];

    logic                 q_empty;
    logic                 q_full;
    logic                 two_plus;
    logic                 head_due;
    logic                 second_due;
    logic                 add_rearm;

    assign new_entry.deadline = i_in_data.time_us;
    assign new_entry.id       = i_in_data.timer_id;

    // The chain of slots. Slot 0 is the head (earliest deadline).
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        sdtq_pkg::t_entry prev_entry;
        sdtq_pkg::t_entry next_entry;
        logic             prev_after;

        if (g == 0) begin : g_head
            assign prev_entry = new_entry;
            assign prev_after = 1'b0;
        end else begin : g_body
            assign prev_entry = c_entry[g-1];
            assign prev_after = c_after[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_entry = c_entry[g];
        end else begin : g_inner
            assign next_entry = c_entry[g+1];
        end

        sdtq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_new        (new_entry),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_prev       (prev_entry),
            .i_prev_after (prev_after),
            .i_next       (next_entry),
            .o_entry      (c_entry[g]),
            .o_after      (c_after[g])
        );
    end

    assign q_empty    = (r_count == '0);
    assign q_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign two_plus   = (r_count > CNT_W'(1));
    assign head_due   = !q_empty && (c_entry[0].deadline <= r_now);
    assign second_due = two_plus && (c_entry[1].deadline <= r_now);
    assign add_rearm  = q_empty || (i_in_data.time_us < c_entry[0].deadline);

    // The result register may take a new result when it is empty or its
    // current result is being transferred this cycle.
    assign can_load = !r_out_valid || i_out_ready;
    assign in_xfer  = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdtq_pkg::S_IDLE: begin
                if (in_xfer && (i_in_data.opcode == sdtq_pkg::OP_EXPIRE)) begin
                    n_state = sdtq_pkg::S_EXPIRE;
                end
            end
            sdtq_pkg::S_EXPIRE: begin
                // Leave once the final result of the expire item is loaded.
                if (can_load && !(head_due && second_due)) begin
                    n_state = sdtq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sdtq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, slot commands, result and count.
    always_comb begin
        o_in_ready       = 1'b0;
        cell_ctrl.insert = 1'b0;
        cell_ctrl.pop    = 1'b0;
        load_out         = 1'b0;
        n_count          = r_count;
        n_out            = '0;
        n_out.last       = 1'b1;
        unique case (r_state)
            sdtq_pkg::S_IDLE: begin
                o_in_ready = can_load;
                if (in_xfer && (i_in_data.opcode == sdtq_pkg::OP_ADD)) begin
                    load_out = 1'b1;
                    if (q_full) begin
                        n_out.kind          = sdtq_pkg::KIND_REJECTED;
                        n_out.next_deadline = c_entry[0].deadline;
                    end else begin
                        cell_ctrl.insert    = 1'b1;
                        n_count             = r_count + CNT_W'(1);
                        n_out.kind          = sdtq_pkg::KIND_ADDED;
                        n_out.rearm         = add_rearm;
                        n_out.next_deadline = add_rearm ? i_in_data.time_us
                                                        : c_entry[0].deadline;
                    end
                end
            end
            sdtq_pkg::S_EXPIRE: begin
                if (can_load) begin
                    load_out = 1'b1;
                    if (head_due) begin
                        cell_ctrl.pop          = 1'b1;
                        n_count                = r_count - CNT_W'(1);
                        n_out.kind             = sdtq_pkg::KIND_EXPIRED;
                        n_out.expired_id       = c_entry[0].id;
                        n_out.expired_deadline = c_entry[0].deadline;
                        n_out.last             = !second_due;
                        if (!second_due) begin
                            n_out.rearm         = two_plus;
                            n_out.queue_empty   = !two_plus;
                            n_out.next_deadline = two_plus ? c_entry[1].deadline : '0;
                        end
                    end else begin
                        // Nothing was due at the captured time.
                        n_out.kind          = sdtq_pkg::KIND_NONE;
                        n_out.rearm         = !q_empty;
                        n_out.queue_empty   = q_empty;
                        n_out.next_deadline = q_empty ? '0 : c_entry[0].deadline;
                    end
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdtq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
        if (in_xfer) begin
            r_now <= i_in_data.time_us;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- tb/tb_sorted_deadline_timer_queue_unit.sv -----
// Self-checking testbench for sorted_deadline_timer_queue_unit: random add and expire
// traffic with an in-bench timer list that predicts every result transfer.
// Depends on sdtq_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue_unit;

    localparam int DEPTH = 32;

    typedef logic [sdtq_pkg::TIME_BITS-1:0] t_time;
    typedef logic [sdtq_pkg::ID_BITS-1:0]   t_id;

    localparam t_time TIME_MAX = '1;

    typedef struct {
        sdtq_pkg::t_in_item item;
        bit                 drain_first;   // hold this item back until every result is in
    } t_stim;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    sdtq_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    sdtq_pkg::t_out_item o_out_data;

    sorted_deadline_timer_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the timer list, kept sorted by deadline then id.
    sdtq_pkg::t_entry    timer_list [DEPTH];
    int                  timer_count = 0;
    sdtq_pkg::t_out_item due_q [$];
    t_stim               stim_q [$];

    int  results_due = 0;
    int  mismatches = 0;
    int  items_in = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    bit  rx_hold = 1'b0;
    int  cyc = 0;
    wire calm = (cyc[8] && cyc[7]);   // stretches in which neither side idles

    int n_adds = 0, n_expires = 0, n_rejects = 0, n_expired = 0, peak_count = 0;

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic t_time rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[sdtq_pkg::TIME_BITS-1:0];
    endfunction

    task automatic add_stim(input logic op, input t_time t,
                            input t_id id, input bit drain = 1'b0);
        t_stim s;
        s.item.opcode   = op;
        s.item.time_us  = t;
        s.item.timer_id = id;
        s.drain_first   = drain;
        stim_q.push_back(s);
    endtask

    // Applies one accepted item to the timer list and queues its results.
    task automatic apply_timer_item(input sdtq_pkg::t_in_item it);
        sdtq_pkg::t_out_item r;
        int                  pos;
        int                  n;
        bit                  empty;
        r = '0;
        if (it.opcode == sdtq_pkg::OP_ADD) begin
            n_adds++;
            if (timer_count >= DEPTH) begin
                r.kind          = sdtq_pkg::KIND_REJECTED;
                r.next_deadline = timer_list[0].deadline;
                r.last          = 1'b1;
                due_q.push_back(r);
                return;
            end
            r.rearm = (timer_count == 0) || (it.time_us < timer_list[0].deadline);
            pos = 0;
            while (pos < timer_count &&
                   (timer_list[pos].deadline < it.time_us ||
                    (timer_list[pos].deadline == it.time_us &&
                     timer_list[pos].id <= it.timer_id)))
                pos++;
            for (int i = timer_count; i > pos; i--)
                timer_list[i] = timer_list[i-1];
            timer_list[pos].deadline = it.time_us;
            timer_list[pos].id       = it.timer_id;
            timer_count++;
            if (timer_count > peak_count)
                peak_count = timer_count;
            r.kind          = sdtq_pkg::KIND_ADDED;
            r.next_deadline = timer_list[0].deadline;
            r.last          = 1'b1;
            due_q.push_back(r);
        end else begin
            n_expires++;
            n = 0;
            while (n < timer_count && timer_list[n].deadline <= it.time_us)
                n++;
            // All but the final expired timer go out as plain results.
            for (int i = 0; i < n; i++) begin
                r                  = '0;
                r.kind             = sdtq_pkg::KIND_EXPIRED;
                r.expired_id       = timer_list[i].id;
                r.expired_deadline = timer_list[i].deadline;
                if (i < n - 1)
                    due_q.push_back(r);
            end
            for (int i = n; i < timer_count; i++)
                timer_list[i-n] = timer_list[i];
            timer_count -= n;
            if (n == 0) begin
                r      = '0;
                r.kind = sdtq_pkg::KIND_NONE;
            end
            empty           = (timer_count == 0);
            r.rearm         = !empty;
            r.next_deadline = empty ? '0 : timer_list[0].deadline;
            r.queue_empty   = empty;
            r.last          = 1'b1;
            due_q.push_back(r);
        end
    endtask

    task automatic compare_result(input sdtq_pkg::t_out_item want,
                                  input sdtq_pkg::t_out_item got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH at %0t: expected kind %0d id %0h dl %0h rearm %0b",
                         $realtime, want.kind, want.expired_id, want.expired_deadline,
                         want.rearm);
                $display("    expected next %0h empty %0b last %0b",
                         want.next_deadline, want.queue_empty, want.last);
                $display("    actual kind %0d id %0h dl %0h rearm %0b",
                         got.kind, got.expired_id, got.expired_deadline, got.rearm);
                $display("    actual next %0h empty %0b last %0b",
                         got.next_deadline, got.queue_empty, got.last);
            end
        end
    endtask

    always @(posedge i_clk)
        cyc <= cyc + 1;

    // Sender: offers the next pending item after a random gap.
    always @(posedge i_clk) begin : drive
        logic               offer;
        sdtq_pkg::t_in_item nxt;
        t_stim              s;
        offer = i_in_valid;
        nxt   = i_in_data;
        if (!i_rst_n) begin
            offer = 1'b0;
            nxt   = '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                tx_gap = draw_gap();
            offer = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (stim_q.size() != 0 &&
                         (!stim_q[0].drain_first || (!i_in_valid && results_due == 0))) begin
                s     = stim_q.pop_front();
                nxt   = s.item;
                offer = 1'b1;
            end
        end
        i_in_valid <= offer;
        i_in_data  <= nxt;
    end

    // Receiver: stalls a random number of cycles after each result transfer.
    always @(posedge i_clk) begin : receive
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                rx_gap = draw_gap();
            if (rx_hold)
                rdy = 1'b0;
            else if (rx_gap > 0)
                rx_gap--;
            else
                rdy = 1'b1;
        end
        i_out_ready <= rdy;
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge i_clk) begin : monitor
        sdtq_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                items_in++;
                apply_timer_item(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                if (o_out_data.kind == sdtq_pkg::KIND_REJECTED)
                    n_rejects++;
                if (o_out_data.kind == sdtq_pkg::KIND_EXPIRED)
                    n_expired++;
                if (due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("MISMATCH at %0t: unexpected result, kind %0d",
                                 $realtime, o_out_data.kind);
                end else begin
                    want = due_q.pop_front();
                    compare_result(want, o_out_data);
                end
            end
            results_due <= due_q.size();
        end
    end

    // Long receiver hold-off while the sender keeps offering items.
    initial begin
        wait (items_in >= 20);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (150) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        t_time base;
        t_time t;
        int span, nadd, nexp, seq, id_hi;
        bit drain;

        // Directed part: empty queue, head ties, duplicates, field extremes.
        add_stim(sdtq_pkg::OP_EXPIRE, '0, 8'h00);          // nothing to expire, empty queue
        add_stim(sdtq_pkg::OP_ADD, 48'd100, 8'd5);         // first timer rearms
        add_stim(sdtq_pkg::OP_ADD, 48'd200, 8'd7);
        add_stim(sdtq_pkg::OP_ADD, 48'd100, 8'd3);         // tie with the head, no rearm
        add_stim(sdtq_pkg::OP_ADD, 48'd100, 8'd5);         // duplicate of a queued timer
        add_stim(sdtq_pkg::OP_ADD, 48'd50, 8'hFF);         // earlier deadline rearms
        add_stim(sdtq_pkg::OP_ADD, '0, 8'h00);
        add_stim(sdtq_pkg::OP_ADD, TIME_MAX, 8'hFF);
        add_stim(sdtq_pkg::OP_ADD, TIME_MAX, 8'h00);
        add_stim(sdtq_pkg::OP_EXPIRE, 48'd49, 8'hFF);      // expires only the zero deadline
        add_stim(sdtq_pkg::OP_EXPIRE, 48'd49, 8'hAA);      // nothing expired, timers remain
        add_stim(sdtq_pkg::OP_EXPIRE, 48'd100, 8'h00);
        add_stim(sdtq_pkg::OP_EXPIRE, TIME_MAX - 1, 8'h55);
        add_stim(sdtq_pkg::OP_EXPIRE, TIME_MAX, 8'h00);    // drains the queue
        add_stim(sdtq_pkg::OP_EXPIRE, TIME_MAX, 8'hFF);
        add_stim(sdtq_pkg::OP_ADD, TIME_MAX, 8'h80);
        add_stim(sdtq_pkg::OP_EXPIRE, TIME_MAX, 8'h01);

        // Random part: mostly add bursts around a base time followed by expires.
        seq = 0;
        while (stim_q.size() < 150) begin
            drain = (seq == 0) || ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 2) begin
                add_stim(1'($urandom_range(0, 1)), rand48(),
                         t_id'($urandom_range(0, 255)), drain);
            end else begin
                case ($urandom_range(0, 3))
                    0:       base = t_time'($urandom_range(0, 1000));
                    1:       base = TIME_MAX - t_time'(5000)
                                    + t_time'($urandom_range(0, 2000));
                    default: base = rand48() >> 1;
                endcase
                span  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 64);
                id_hi = ($urandom_range(0, 2) == 0) ? 3 : 255;
                nadd  = (seq == 2) ? 34 : $urandom_range(1, 10);
                for (int i = 0; i < nadd; i++)
                    add_stim(sdtq_pkg::OP_ADD, base + t_time'($urandom_range(0, span)),
                             t_id'($urandom_range(0, id_hi)), drain && (i == 0));
                if ($urandom_range(0, 3) == 0 && base != 0)
                    add_stim(sdtq_pkg::OP_EXPIRE, base - 1, t_id'($urandom_range(0, 255)));
                nexp = $urandom_range(1, 3);
                t = base;
                for (int i = 0; i < nexp; i++) begin
                    t = t + t_time'($urandom_range(0, span / 2 + 1));
                    add_stim(sdtq_pkg::OP_EXPIRE, t, t_id'($urandom_range(0, 255)));
                end
                if (seq == 2)
                    add_stim(sdtq_pkg::OP_EXPIRE, TIME_MAX, t_id'($urandom_range(0, 255)));
            end
            seq++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (!(stim_q.size() == 0 && !i_in_valid && results_due == 0));
        repeat (40) @(posedge i_clk);

        $display("Ran %0d items: %0d adds (%0d rejected when full), %0d expire checks.",
                 items_in, n_adds, n_rejects, n_expires);
        $display("Expired %0d timers; the list peaked at %0d of %0d entries.",
                 n_expired, peak_count, DEPTH);
        if (due_q.size() != 0) begin
            $display("%0d expected results never arrived", due_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sorted_deadline_timer_queue_unit.f -----
src/sdtq_pkg.sv
src/sdtq_cell.sv
src/sorted_deadline_timer_queue_unit.sv
tb/tb_sorted_deadline_timer_queue_unit.sv
